/* hw/rtl/ckv_pkg.sv */
package ckv_pkg;

  localparam int unsigned ENTRIES_DEF   = 1024;
  localparam int unsigned BUCKETS_DEF   = 4096;
  localparam int unsigned KEY_BYTES_DEF = 32;

  localparam logic [5:0]  KEY_SIZE_RST = 6'd32;
  localparam logic [31:0] DJB2_INIT    = 32'd5381;

  localparam logic [1:0] OP_FIND = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_KEY_BIG   = 2'd2,
    ST_NO_SPACE  = 2'd3
  } ckv_status_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         key_len;
    logic [63:0]        key_word0;
    logic [63:0]        key_word1;
    logic [63:0]        key_word2;
    logic [63:0]        key_word3;
    logic signed [63:0] new_value;
  } ckv_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] found_value;
    logic [10:0]        element_count;
    logic [31:0]        read_count;
    logic [31:0]        write_count;
    logic [31:0]        hit_count;
    logic [31:0]        miss_count;
  } ckv_rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } ckv_q_ctrl_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } ckv_front_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BKT,
    S_WALK,
    S_CMP,
    S_ACT,
    S_ADD_RD,
    S_W1,
    S_W2,
    S_W3,
    S_DONE
  } ckv_back_e;

endpackage

/* hw/rtl/ckv_fifo.sv */
module ckv_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign wptr_d  = do_push ? !wptr_q : wptr_q;
  assign rptr_d  = do_pop ? !rptr_q : rptr_q;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule

/* hw/rtl/ckv_front.sv */
module ckv_front #(
  parameter int unsigned BUCKETS   = ckv_pkg::BUCKETS_DEF,
  parameter int unsigned KEY_BYTES = ckv_pkg::KEY_BYTES_DEF,
  localparam int unsigned KEY_W    = KEY_BYTES * 8,
  localparam int unsigned BW       = $clog2(BUCKETS),
  localparam int unsigned ITEM_W   = 2 + 1 + KEY_W + 64 + BW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              clear_busy_i,
  output logic              busy,
  input  ckv_pkg::ckv_req_t req_i,
  input  logic [5:0]        ks_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output logic [ITEM_W-1:0] q_data_o
);

  localparam logic [31:0] BKT32 = 32'(BUCKETS);
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));

  ckv_pkg::ckv_front_e state_q, state_d;

  logic [1:0]       op_q;
  logic [7:0]       len_q;
  logic             over_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] hkey_q;
  logic [63:0]      val_q;
  logic [31:0]      h_q;
  logic [5:0]       i_q;
  logic [4:0]       bit_q;
  logic [BW-1:0]    r_q;
  logic [63:0]      prod_q;
  logic [31:0]      rem_q;

  logic             accept;
  logic             over;
  logic [255:0]     key_all;
  logic [KEY_W-1:0] key_in;
  logic [31:0]      h_step;

  assign accept  = start && !busy;
  assign busy    = (state_q != ckv_pkg::F_IDLE) || clear_busy_i;
  assign over    = req_i.key_len > {2'b00, ks_i};
  assign key_all = {req_i.key_word3, req_i.key_word2, req_i.key_word1, req_i.key_word0};

  // Bytes at and beyond the supplied length are zero padded.
  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_in[b*8 +: 8] = (b < int'(req_i.key_len)) ? key_all[b*8 +: 8] : 8'h00;
    end
  end

  assign h_step  = (h_q << 5) + h_q + {24'd0, hkey_q[7:0]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ckv_pkg::F_IDLE: begin
        if (accept) begin
          if (req_i.opcode == ckv_pkg::OP_NONE || over) begin
            state_d = ckv_pkg::F_PUSH;
          end else if (req_i.key_len == 8'd0) begin
            state_d = ckv_pkg::F_MOD;
          end else begin
            state_d = ckv_pkg::F_HASH;
          end
        end
      end
      ckv_pkg::F_HASH: begin
        if ({2'b00, i_q} + 8'd1 == len_q) begin
          state_d = ckv_pkg::F_MOD;
        end
      end
      ckv_pkg::F_MOD: begin
        if (bit_q == 5'd3) begin
          state_d = ckv_pkg::F_PUSH;
        end
      end
      ckv_pkg::F_PUSH: begin
        if (!q_full_i) begin
          state_d = ckv_pkg::F_IDLE;
        end
      end
      default: state_d = ckv_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    q_push_o = (state_q == ckv_pkg::F_PUSH) && !q_full_i;
    q_data_o = {op_q, over_q, key_q, val_q, r_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ckv_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ckv_pkg::F_IDLE: begin
        op_q   <= req_i.opcode;
        len_q  <= req_i.key_len;
        over_q <= over;
        key_q  <= key_in;
        hkey_q <= key_in;
        val_q  <= req_i.new_value;
        h_q    <= ckv_pkg::DJB2_INIT;
        i_q    <= 6'd0;
        bit_q  <= 5'd0;
        r_q    <= '0;
      end
      ckv_pkg::F_HASH: begin
        h_q    <= h_step;
        hkey_q <= hkey_q >> 8;
        i_q    <= i_q + 6'd1;
      end
      ckv_pkg::F_MOD: begin
        // The reciprocal estimate of the quotient is at most one low, so a
        // compare and subtract brings the remainder into range.
        case (bit_q)
          5'd0: prod_q <= {32'd0, h_q} * {32'd0, RECIP};
          5'd1: rem_q <= h_q - prod_q[63:32] * BKT32;
          5'd2: begin
            if (rem_q >= BKT32) begin
              rem_q <= rem_q - BKT32;
            end
          end
          default: r_q <= (rem_q >= BKT32) ? BW'(rem_q - BKT32) : BW'(rem_q);
        endcase
        bit_q <= bit_q + 5'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/ckv_back.sv */
module ckv_back #(
  parameter int unsigned ENTRIES   = ckv_pkg::ENTRIES_DEF,
  parameter int unsigned BUCKETS   = ckv_pkg::BUCKETS_DEF,
  parameter int unsigned KEY_BYTES = ckv_pkg::KEY_BYTES_DEF,
  localparam int unsigned KEY_W    = KEY_BYTES * 8,
  localparam int unsigned BW       = $clog2(BUCKETS),
  localparam int unsigned ITEM_W   = 2 + 1 + KEY_W + 64 + BW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        ks_i,
  input  logic              q_empty_i,
  input  logic [ITEM_W-1:0] q_data_i,
  output logic              q_pop_o,
  output logic              clear_busy_o,
  output logic              done,
  output ckv_pkg::ckv_rsp_t rsp_o
);

  localparam int unsigned IW   = $clog2(ENTRIES + 1);
  localparam int unsigned AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CLR  = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
  localparam int unsigned CLRW = $clog2(CLR);
  localparam logic [IW-1:0] NIL = IW'(ENTRIES);

  ckv_pkg::ckv_back_e state_q, state_d;

  logic [IW-1:0] head_mem [BUCKETS];
  logic [IW-1:0] count_mem [BUCKETS];
  logic [IW-1:0] next_mem [ENTRIES];
  logic [IW-1:0] prev_mem [ENTRIES];
  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [63:0]   val_mem [ENTRIES];

  logic [IW-1:0]    hd_rd, ct_rd, nx_rd, pv_rd;
  logic [KEY_W-1:0] key_rd;
  logic [63:0]      val_rd;

  logic             bk_we_h, bk_we_c;
  logic [BW-1:0]    bk_wa, bk_ra;
  logic [IW-1:0]    hd_wd, ct_wd;
  logic             nx_we, pv_we, key_we, val_we;
  logic [AW-1:0]    nx_wa, pv_wa, kv_wa, en_ra;
  logic [IW-1:0]    nx_wd, pv_wd;
  logic [63:0]      val_wd;

  logic [CLRW-1:0]  clr_q;
  logic [IW-1:0]    clr_e;

  logic [1:0]       it_op;
  logic             it_over;
  logic [KEY_W-1:0] it_key;
  logic [63:0]      it_val;
  logic [BW-1:0]    it_bkt;

  logic [IW-1:0]    idx_q, head_q, cnt_q, n_q, nx_q, pv_q, fhn_q;
  logic [63:0]      val_q;
  logic             hit_q, full_q;
  logic [IW-1:0]    free_head_q;
  logic [IW-1:0]    free_count_q;
  logic [31:0]      rd_cnt_q, wr_cnt_q, hit_cnt_q, miss_cnt_q;

  logic [KEY_W-1:0] cmask;
  logic             match, walk_ok, free_empty;
  logic             is_find, is_add, is_del, wrote;
  logic [1:0]       status;
  logic [31:0]      used;

  assign clr_e = IW'(clr_q[AW-1:0]);

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      cmask[b*8 +: 8] = (b < int'(ks_i)) ? 8'hFF : 8'h00;
    end
  end

  assign match      = ((key_rd ^ it_key) & cmask) == '0;
  assign walk_ok    = (idx_q < NIL) && (n_q < cnt_q) && (n_q < NIL);
  assign free_empty = free_head_q >= NIL;
  assign is_find    = !it_over && (it_op == ckv_pkg::OP_FIND);
  assign is_add     = !it_over && (it_op == ckv_pkg::OP_ADD);
  assign is_del     = !it_over && (it_op == ckv_pkg::OP_DEL);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ckv_pkg::S_CLEAR: begin
        if (clr_q == CLRW'(CLR - 1)) begin
          state_d = ckv_pkg::S_IDLE;
        end
      end
      ckv_pkg::S_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i[ITEM_W-1 -: 2] == ckv_pkg::OP_NONE || q_data_i[ITEM_W-3]) begin
            state_d = ckv_pkg::S_DONE;
          end else begin
            state_d = ckv_pkg::S_BKT;
          end
        end
      end
      ckv_pkg::S_BKT:  state_d = ckv_pkg::S_WALK;
      ckv_pkg::S_WALK: state_d = walk_ok ? ckv_pkg::S_CMP : ckv_pkg::S_ACT;
      ckv_pkg::S_CMP:  state_d = match ? ckv_pkg::S_ACT : ckv_pkg::S_WALK;
      ckv_pkg::S_ACT: begin
        if (is_add && !hit_q && !free_empty) begin
          state_d = ckv_pkg::S_ADD_RD;
        end else if (is_del && hit_q) begin
          state_d = ckv_pkg::S_W1;
        end else begin
          state_d = ckv_pkg::S_DONE;
        end
      end
      ckv_pkg::S_ADD_RD: state_d = ckv_pkg::S_W1;
      ckv_pkg::S_W1:     state_d = ckv_pkg::S_W2;
      ckv_pkg::S_W2:     state_d = ckv_pkg::S_W3;
      ckv_pkg::S_W3:     state_d = ckv_pkg::S_DONE;
      ckv_pkg::S_DONE:   state_d = ckv_pkg::S_IDLE;
      default:           state_d = ckv_pkg::S_IDLE;
    endcase
  end

  // Memory port controls; each store takes one write per cycle, so the
  // link updates of an add or a delete are spread over S_W1, S_W2 and S_W3.
  always_comb begin
    q_pop_o = 1'b0;
    bk_we_h = 1'b0;
    bk_we_c = 1'b0;
    bk_wa   = it_bkt;
    bk_ra   = q_data_i[BW-1:0];
    hd_wd   = NIL;
    ct_wd   = '0;
    nx_we   = 1'b0;
    nx_wa   = '0;
    nx_wd   = NIL;
    pv_we   = 1'b0;
    pv_wa   = '0;
    pv_wd   = NIL;
    key_we  = 1'b0;
    val_we  = 1'b0;
    kv_wa   = free_head_q[AW-1:0];
    val_wd  = it_val;
    en_ra   = idx_q[AW-1:0];
    case (state_q)
      ckv_pkg::S_CLEAR: begin
        if (32'(clr_q) < BUCKETS) begin
          bk_we_h = 1'b1;
          bk_we_c = 1'b1;
        end
        bk_wa = clr_q[BW-1:0];
        if (32'(clr_q) < ENTRIES) begin
          nx_we = 1'b1;
          pv_we = 1'b1;
        end
        nx_wa = clr_q[AW-1:0];
        pv_wa = clr_q[AW-1:0];
        nx_wd = clr_e + IW'(1);
        pv_wd = (clr_e == '0) ? NIL : clr_e - IW'(1);
      end
      ckv_pkg::S_IDLE: begin
        q_pop_o = !q_empty_i;
      end
      ckv_pkg::S_ACT: begin
        en_ra = free_head_q[AW-1:0];
        if (is_add && hit_q) begin
          val_we = 1'b1;
          kv_wa  = idx_q[AW-1:0];
        end
      end
      ckv_pkg::S_W1: begin
        if (is_add) begin
          pv_we   = fhn_q < NIL;
          pv_wa   = fhn_q[AW-1:0];
          nx_we   = 1'b1;
          nx_wa   = free_head_q[AW-1:0];
          nx_wd   = head_q;
          bk_we_h = 1'b1;
          hd_wd   = free_head_q;
          bk_we_c = 1'b1;
          ct_wd   = cnt_q + IW'(1);
          key_we  = 1'b1;
          val_we  = 1'b1;
        end else begin
          pv_we   = nx_q < NIL;
          pv_wa   = nx_q[AW-1:0];
          pv_wd   = pv_q;
          nx_we   = pv_q < NIL;
          nx_wa   = pv_q[AW-1:0];
          nx_wd   = nx_q;
          bk_we_h = head_q == idx_q;
          hd_wd   = nx_q;
          bk_we_c = 1'b1;
          ct_wd   = cnt_q - IW'(1);
        end
      end
      ckv_pkg::S_W2: begin
        if (is_add) begin
          pv_we = 1'b1;
          pv_wa = free_head_q[AW-1:0];
        end else begin
          pv_we = !free_empty;
          pv_wa = free_head_q[AW-1:0];
          pv_wd = idx_q;
          nx_we = 1'b1;
          nx_wa = idx_q[AW-1:0];
          nx_wd = free_head_q;
        end
      end
      ckv_pkg::S_W3: begin
        if (is_add) begin
          pv_we = head_q < NIL;
          pv_wa = head_q[AW-1:0];
          pv_wd = free_head_q;
        end else begin
          pv_we = 1'b1;
          pv_wa = idx_q[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bk_we_h) begin
      head_mem[bk_wa] <= hd_wd;
    end
    hd_rd <= head_mem[bk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bk_we_c) begin
      count_mem[bk_wa] <= ct_wd;
    end
    ct_rd <= count_mem[bk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    nx_rd <= next_mem[en_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    pv_rd <= prev_mem[en_ra];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[kv_wa] <= it_key;
    end
    key_rd <= key_mem[en_ra];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[kv_wa] <= val_wd;
    end
    val_rd <= val_mem[en_ra];
  end

  always_comb begin
    status = ckv_pkg::ST_OK;
    if (it_op == ckv_pkg::OP_NONE) begin
      status = ckv_pkg::ST_NOT_FOUND;
    end else if (it_over) begin
      status = ckv_pkg::ST_KEY_BIG;
    end else if (!hit_q) begin
      if (it_op != ckv_pkg::OP_ADD) begin
        status = ckv_pkg::ST_NOT_FOUND;
      end else if (full_q) begin
        status = ckv_pkg::ST_NO_SPACE;
      end
    end
  end

  assign wrote = (is_add && (hit_q || !full_q)) || (is_del && hit_q);
  assign used  = 32'(ENTRIES) - 32'(free_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ckv_pkg::S_CLEAR;
      clr_q        <= '0;
      free_head_q  <= '0;
      free_count_q <= IW'(ENTRIES);
      rd_cnt_q     <= '0;
      wr_cnt_q     <= '0;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      done         <= 1'b0;
    end else begin
      state_q <= state_d;
      done    <= state_q == ckv_pkg::S_DONE;
      if (state_q == ckv_pkg::S_CLEAR) begin
        clr_q <= clr_q + CLRW'(1);
      end
      if (state_q == ckv_pkg::S_W3) begin
        if (is_add) begin
          free_head_q  <= fhn_q;
          free_count_q <= free_count_q - IW'(1);
        end else begin
          free_head_q  <= idx_q;
          free_count_q <= free_count_q + IW'(1);
        end
      end
      if (state_q == ckv_pkg::S_DONE) begin
        if (it_op == ckv_pkg::OP_FIND) begin
          rd_cnt_q <= rd_cnt_q + 32'd1;
          if (hit_q) begin
            hit_cnt_q <= hit_cnt_q + 32'd1;
          end else begin
            miss_cnt_q <= miss_cnt_q + 32'd1;
          end
        end
        if (wrote) begin
          wr_cnt_q <= wr_cnt_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ckv_pkg::S_IDLE: begin
        {it_op, it_over, it_key, it_val, it_bkt} <= q_data_i;
        hit_q  <= 1'b0;
        full_q <= 1'b0;
      end
      ckv_pkg::S_BKT: begin
        idx_q  <= hd_rd;
        head_q <= hd_rd;
        cnt_q  <= ct_rd;
        n_q    <= '0;
      end
      ckv_pkg::S_CMP: begin
        if (match) begin
          hit_q <= 1'b1;
          nx_q  <= nx_rd;
          pv_q  <= pv_rd;
          val_q <= val_rd;
        end else begin
          idx_q <= nx_rd;
          n_q   <= n_q + IW'(1);
        end
      end
      ckv_pkg::S_ACT: begin
        full_q <= free_empty;
      end
      ckv_pkg::S_ADD_RD: begin
        fhn_q <= nx_rd;
      end
      ckv_pkg::S_DONE: begin
        rsp_o.status        <= status;
        rsp_o.found_value   <= (is_find && hit_q) ? val_q : '1;
        rsp_o.element_count <= used[10:0];
        rsp_o.read_count    <= (it_op == ckv_pkg::OP_FIND) ? rd_cnt_q + 32'd1 : rd_cnt_q;
        rsp_o.write_count   <= wrote ? wr_cnt_q + 32'd1 : wr_cnt_q;
        rsp_o.hit_count     <= (it_op == ckv_pkg::OP_FIND && hit_q) ?
                               hit_cnt_q + 32'd1 : hit_cnt_q;
        rsp_o.miss_count    <= (it_op == ckv_pkg::OP_FIND && !hit_q) ?
                               miss_cnt_q + 32'd1 : miss_cnt_q;
      end
      default: begin
      end
    endcase
  end

  assign clear_busy_o = state_q == ckv_pkg::S_CLEAR;

endmodule

/* hw/rtl/chained_key_value_table_top.sv */
// Chained key/value table: find, add-or-replace and delete on keys of up to
// KEY_BYTES bytes, each mapped to a signed 64-bit value.
// Request channel: a word is taken at a clock edge where start is high and
// busy is low. Result channel: done is high for exactly one cycle with the
// result on rsp_o; the receiver must take it then, it cannot stall.
// The front part hashes one key byte per cycle and reduces the hash to a
// bucket with a reciprocal multiply, a subtract and compare-and-subtract
// corrections; it holds busy until the word is pushed into the queue (an
// oversize key or the unused opcode skips both). A two-word queue lets the
// next word be hashed while the back part walks the chain. The back part
// reads the bucket, visits chain entries via S_WALK and S_CMP and acts; an
// insert reads the free list, then an insert or delete writes the links in
// S_W1 to S_W3 and S_DONE registers the result. Accept to done spans both
// parts plus queue waiting. Sustained rate is set by the slower of the hash
// loop and the chain walk. After reset the back part clears bucket heads and
// counts and rebuilds the free list, one entry a cycle; busy stays high then.
// The key_size register may be written at any time the block is idle.
module chained_key_value_table_top #(
  parameter int unsigned ENTRIES   = ckv_pkg::ENTRIES_DEF,
  parameter int unsigned BUCKETS   = ckv_pkg::BUCKETS_DEF,
  parameter int unsigned KEY_BYTES = ckv_pkg::KEY_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ckv_pkg::ckv_req_t req_i,
  output logic              done,
  output ckv_pkg::ckv_rsp_t rsp_o,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i
);

  localparam int unsigned KEY_W  = KEY_BYTES * 8;
  localparam int unsigned BW     = $clog2(BUCKETS);
  localparam int unsigned ITEM_W = 2 + 1 + KEY_W + 64 + BW;

  logic [5:0]        key_size_q;
  logic [5:0]        ks;
  logic              clear_busy;
  ckv_pkg::ckv_q_ctrl_t q_ctrl;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= ckv_pkg::KEY_SIZE_RST;
    end else if (cfg_we_i) begin
      key_size_q <= cfg_wdata_i;
    end
  end

  assign ks = (key_size_q > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : key_size_q;

  ckv_front #(
    .BUCKETS   (BUCKETS),
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .clear_busy_i (clear_busy),
    .busy         (busy),
    .req_i        (req_i),
    .ks_i         (ks),
    .q_full_i     (q_ctrl.full),
    .q_push_o     (q_ctrl.push),
    .q_data_o     (q_wdata)
  );

  ckv_fifo #(
    .WIDTH (ITEM_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_ctrl.push),
    .data_i  (q_wdata),
    .pop_i   (q_ctrl.pop),
    .data_o  (q_rdata),
    .full_o  (q_ctrl.full),
    .empty_o (q_ctrl.empty)
  );

  ckv_back #(
    .ENTRIES   (ENTRIES),
    .BUCKETS   (BUCKETS),
    .KEY_BYTES (KEY_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ks_i         (ks),
    .q_empty_i    (q_ctrl.empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_ctrl.pop),
    .clear_busy_o (clear_busy),
    .done         (done),
    .rsp_o        (rsp_o)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("front part did not take the accepted word");

  a_no_space_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && rsp_o.status == ckv_pkg::ST_NO_SPACE) |-> (rsp_o.found_value == '1))
    else $error("full-table result carries a found value");

  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> (!q_ctrl.pop && !done))
    else $error("queue served during the clearing pass");
`endif

endmodule
